// ----- design/pebs_pkg.sv -----
`timescale 1ns / 1ps
// package for the particle euler step block: field widths, command and
// register codes, saturation helpers; used by the interfaces and the top level
package pebs_pkg;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned MODE_W  = 3;
	localparam int unsigned DAMP_W  = 31;
	localparam int unsigned AREA_W  = 15;
	localparam int unsigned MASS_W  = 16;
	localparam int unsigned CIDX_W  = 3;

	localparam logic [MODE_W-1:0] MODE_FORCE   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_DAMP    = 3'd1;
	localparam logic [MODE_W-1:0] MODE_INTEG   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_BOUNCE  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_RESTART = 3'd4;

	localparam logic [CIDX_W-1:0] REG_AREA_W  = 3'd0;
	localparam logic [CIDX_W-1:0] REG_AREA_H  = 3'd1;
	localparam logic [CIDX_W-1:0] REG_MASS    = 3'd2;
	localparam logic [CIDX_W-1:0] REG_START_X = 3'd3;
	localparam logic [CIDX_W-1:0] REG_START_Y = 3'd4;
	localparam logic [CIDX_W-1:0] REG_START_Z = 3'd5;

	localparam logic [AREA_W-1:0] AREA_W_RST = 15'd1024;
	localparam logic [AREA_W-1:0] AREA_H_RST = 15'd768;
	localparam logic [MASS_W-1:0] MASS_RST   = 16'd256;

	localparam logic signed [WORD_W-1:0] S32_MAX = 32'sh7fffffff;
	localparam logic signed [WORD_W-1:0] S32_MIN = 32'sh80000000;

	// clamp a 34-bit signed sum to the 32-bit range
	function automatic logic signed [WORD_W-1:0] sat34(input logic signed [33:0] v);
		logic signed [WORD_W-1:0] r;
		if (v > 34'sh0_7fffffff) begin
			r = S32_MAX;
		end else if (v < -34'sh0_80000000) begin
			r = S32_MIN;
		end else begin
			r = v[WORD_W-1:0];
		end
		return r;
	endfunction

	// negate, most negative value goes to most positive
	function automatic logic signed [WORD_W-1:0] neg_sat(input logic signed [WORD_W-1:0] v);
		logic signed [WORD_W-1:0] r;
		if (v == S32_MIN) begin
			r = S32_MAX;
		end else begin
			r = -v;
		end
		return r;
	endfunction

endpackage

// ----- design/pebs_cmd_if.sv -----
`timescale 1ns / 1ps
// command channel: mode, force vector and damping magnitude
// depends on pebs_pkg
interface pebs_cmd_if;
	logic                                valid;
	logic                                ready;
	logic [pebs_pkg::MODE_W-1:0]         mode;
	logic signed [pebs_pkg::WORD_W-1:0]  force_x;
	logic signed [pebs_pkg::WORD_W-1:0]  force_y;
	logic signed [pebs_pkg::WORD_W-1:0]  force_z;
	logic [pebs_pkg::DAMP_W-1:0]         damping;

	modport source (output valid, mode, force_x, force_y, force_z, damping, input ready);
	modport sink   (input valid, mode, force_x, force_y, force_z, damping, output ready);
endinterface

// ----- design/pebs_res_if.sv -----
`timescale 1ns / 1ps
// result channel: position and velocity after each command
// depends on pebs_pkg
interface pebs_res_if;
	logic                                valid;
	logic                                ready;
	logic signed [pebs_pkg::WORD_W-1:0]  pos_x;
	logic signed [pebs_pkg::WORD_W-1:0]  pos_y;
	logic signed [pebs_pkg::WORD_W-1:0]  pos_z;
	logic signed [pebs_pkg::WORD_W-1:0]  vel_x;
	logic signed [pebs_pkg::WORD_W-1:0]  vel_y;
	logic signed [pebs_pkg::WORD_W-1:0]  vel_z;

	modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, input ready);
	modport sink   (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, output ready);
endinterface

// ----- design/pebs_cfg_if.sv -----
`timescale 1ns / 1ps
// configuration write channel: register index and data
// depends on pebs_pkg
interface pebs_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [pebs_pkg::CIDX_W-1:0]         index;
	logic [pebs_pkg::WORD_W-1:0]         data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/particle_euler_step_with_bounce.sv -----
`timescale 1ns / 1ps
// one particle, euler integration with wall bounce; one command per beat
// steps: force runs 3 x 40-step restoring divide; damping runs 3 squares,
// a 32-step root and 3 x 64-step divide; integrate, restart, bounce and
// unused codes use no divide. one command in flight; the next is taken while
// a result waits. arst_n clears state to zero and registers to reset values
// depends on pebs_pkg and the pebs_*_if interfaces
module particle_euler_step_with_bounce (
	input  logic       clk,
	input  logic       arst_n,
	pebs_cmd_if.sink   cmd,
	pebs_res_if.source result,
	pebs_cfg_if.sink   cfg
);

	localparam int unsigned W = pebs_pkg::WORD_W;

	typedef enum logic [3:0] {
		ST_IDLE, ST_F_LOAD, ST_DIV, ST_ACC, ST_SQ_MUL, ST_SQ_ADD, ST_SQRT,
		ST_D_MUL, ST_D_LOAD, ST_INT_V, ST_INT_P, ST_BOUNCE, ST_RESTART, ST_DONE
	} state_t;

	state_t state_q;

	logic [pebs_pkg::AREA_W-1:0] area_w_q, area_h_q;
	logic [pebs_pkg::MASS_W-1:0] mass_q;
	logic signed [W-1:0] start_q [3];

	logic signed [W-1:0] pos_q [3];
	logic signed [W-1:0] vel_q [3];
	logic signed [W-1:0] acc_q [3];

	logic [pebs_pkg::MODE_W-1:0] mode_q;
	logic signed [W-1:0]         frc_q [3];
	logic [pebs_pkg::DAMP_W-1:0] damp_q;

	logic [1:0]  k_q;
	logic [6:0]  cnt_q;
	logic [63:0] num_q;
	logic [63:0] quot_q;
	logic [32:0] rem_q;
	logic [31:0] den_q;
	logic        neg_q;
	logic [63:0] prod_q;
	logic [63:0] sum_q;
	logic [35:0] sq_rem_q;
	logic [31:0] root_q;
	logic        res_valid_q;
	logic signed [W-1:0] res_pos_q [3];
	logic signed [W-1:0] res_vel_q [3];

	// divide step, one quotient bit per cycle
	logic [32:0] div_try;
	logic        div_ge;
	assign div_try = {rem_q[31:0], num_q[63]};
	assign div_ge  = div_try >= {1'b0, den_q};

	// square root step, two radicand bits per cycle
	logic [35:0] sq_try, sq_trial;
	logic        sq_ge;
	assign sq_try   = {sq_rem_q[33:0], num_q[63:62]};
	assign sq_trial = {2'b00, root_q, 2'b01};
	assign sq_ge    = sq_try >= sq_trial;

	// operand magnitudes
	logic signed [W-1:0] f_cur, v_cur;
	logic [W-1:0]        f_mag, v_mag;
	assign f_cur = frc_q[k_q];
	assign v_cur = vel_q[k_q];
	assign f_mag = f_cur[W-1] ? W'(-f_cur) : W'(f_cur);
	assign v_mag = v_cur[W-1] ? W'(-v_cur) : W'(v_cur);

	// saturated signed quotient and acceleration update
	logic signed [33:0] q_s, acc_sum;
	always_comb begin
		if (!neg_q) begin
			q_s = (quot_q > 64'h7fffffff) ? 34'sh0_7fffffff : $signed({2'b00, quot_q[31:0]});
		end else if (quot_q >= 64'h80000000) begin
			q_s = -34'sh0_80000000;
		end else begin
			q_s = -$signed({2'b00, quot_q[31:0]});
		end
		if (mode_q == pebs_pkg::MODE_FORCE) begin
			acc_sum = 34'(acc_q[k_q]) + q_s;
		end else begin
			acc_sum = 34'(acc_q[k_q]) - q_s;
		end
	end

	logic signed [W-1:0] edge_x, edge_y;
	assign edge_x = $signed({1'b0, area_w_q, 16'b0});
	assign edge_y = $signed({1'b0, area_h_q, 16'b0});

	logic out_free;
	assign out_free = !res_valid_q || result.ready;

	assign cmd.ready    = (state_q == ST_IDLE);
	assign cfg.ready    = 1'b1;
	assign result.valid = res_valid_q;
	assign result.pos_x = res_pos_q[0];
	assign result.pos_y = res_pos_q[1];
	assign result.pos_z = res_pos_q[2];
	assign result.vel_x = res_vel_q[0];
	assign result.vel_y = res_vel_q[1];
	assign result.vel_z = res_vel_q[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
			area_w_q    <= pebs_pkg::AREA_W_RST;
			area_h_q    <= pebs_pkg::AREA_H_RST;
			mass_q      <= pebs_pkg::MASS_RST;
			for (int i = 0; i < 3; i++) begin
				start_q[i] <= '0;
				pos_q[i]   <= '0;
				vel_q[i]   <= '0;
				acc_q[i]   <= '0;
			end
		end else begin
			if (state_q == ST_DONE && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && result.ready) begin
				res_valid_q <= 1'b0;
			end
			if (cfg.valid) begin
				case (cfg.index)
					pebs_pkg::REG_AREA_W:  area_w_q   <= cfg.data[pebs_pkg::AREA_W-1:0];
					pebs_pkg::REG_AREA_H:  area_h_q   <= cfg.data[pebs_pkg::AREA_W-1:0];
					pebs_pkg::REG_MASS:    mass_q     <= cfg.data[pebs_pkg::MASS_W-1:0];
					pebs_pkg::REG_START_X: start_q[0] <= $signed(cfg.data);
					pebs_pkg::REG_START_Y: start_q[1] <= $signed(cfg.data);
					pebs_pkg::REG_START_Z: start_q[2] <= $signed(cfg.data);
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.valid) begin
						mode_q   <= cmd.mode;
						frc_q[0] <= cmd.force_x;
						frc_q[1] <= cmd.force_y;
						frc_q[2] <= cmd.force_z;
						damp_q   <= cmd.damping;
						k_q      <= 2'd0;
						sum_q    <= '0;
						case (cmd.mode)
							pebs_pkg::MODE_FORCE:   state_q <= ST_F_LOAD;
							pebs_pkg::MODE_DAMP:    state_q <= ST_SQ_MUL;
							pebs_pkg::MODE_INTEG:   state_q <= ST_INT_V;
							pebs_pkg::MODE_BOUNCE:  state_q <= ST_BOUNCE;
							pebs_pkg::MODE_RESTART: state_q <= ST_RESTART;
							default:                state_q <= ST_DONE;
						endcase
					end
				end
				ST_F_LOAD: begin
					// |f| * 256, left aligned so only 40 steps are needed
					num_q   <= {f_mag, 32'b0};
					den_q   <= {16'b0, (mass_q == '0) ? 16'd1 : mass_q};
					neg_q   <= f_cur[W-1];
					cnt_q   <= 7'd40;
					rem_q   <= '0;
					quot_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q   <= div_ge ? (div_try - {1'b0, den_q}) : div_try;
					quot_q  <= {quot_q[62:0], div_ge};
					num_q   <= {num_q[62:0], 1'b0};
					cnt_q   <= cnt_q - 7'd1;
					if (cnt_q == 7'd1) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					acc_q[k_q] <= pebs_pkg::sat34(acc_sum);
					k_q        <= k_q + 2'd1;
					if (k_q == 2'd2) begin
						state_q <= ST_DONE;
					end else if (mode_q == pebs_pkg::MODE_FORCE) begin
						state_q <= ST_F_LOAD;
					end else begin
						state_q <= ST_D_MUL;
					end
				end
				ST_SQ_MUL: begin
					prod_q  <= 64'(v_mag) * 64'(v_mag);
					state_q <= ST_SQ_ADD;
				end
				ST_SQ_ADD: begin
					sum_q <= sum_q + prod_q;
					k_q   <= k_q + 2'd1;
					if (k_q == 2'd2) begin
						num_q    <= sum_q + prod_q;
						sq_rem_q <= '0;
						root_q   <= '0;
						cnt_q    <= 7'd32;
						state_q  <= ((sum_q + prod_q) == '0) ? ST_DONE : ST_SQRT;
					end else begin
						state_q <= ST_SQ_MUL;
					end
				end
				ST_SQRT: begin
					sq_rem_q <= sq_ge ? (sq_try - sq_trial) : sq_try;
					root_q   <= {root_q[30:0], sq_ge};
					num_q    <= {num_q[61:0], 2'b00};
					cnt_q    <= cnt_q - 7'd1;
					if (cnt_q == 7'd1) begin
						k_q     <= 2'd0;
						state_q <= ST_D_MUL;
					end
				end
				ST_D_MUL: begin
					prod_q  <= 64'(v_mag) * 64'(damp_q);
					neg_q   <= v_cur[W-1];
					state_q <= ST_D_LOAD;
				end
				ST_D_LOAD: begin
					num_q   <= prod_q;
					den_q   <= root_q;
					cnt_q   <= 7'd64;
					rem_q   <= '0;
					quot_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_INT_V: begin
					vel_q[k_q] <= pebs_pkg::sat34(34'(vel_q[k_q]) + 34'(acc_q[k_q]));
					state_q    <= ST_INT_P;
				end
				ST_INT_P: begin
					pos_q[k_q] <= pebs_pkg::sat34(34'(pos_q[k_q]) + 34'(vel_q[k_q]));
					acc_q[k_q] <= '0;
					k_q        <= k_q + 2'd1;
					state_q    <= (k_q == 2'd2) ? ST_DONE : ST_INT_V;
				end
				ST_BOUNCE: begin
					if (pos_q[0] < 0) begin
						pos_q[0] <= '0;
						vel_q[0] <= pebs_pkg::neg_sat(vel_q[0]);
					end else if (pos_q[0] > edge_x) begin
						pos_q[0] <= edge_x;
						vel_q[0] <= pebs_pkg::neg_sat(vel_q[0]);
					end
					if (pos_q[1] < 0) begin
						pos_q[1] <= '0;
						vel_q[1] <= pebs_pkg::neg_sat(vel_q[1]);
					end else if (pos_q[1] > edge_y) begin
						pos_q[1] <= edge_y;
						vel_q[1] <= pebs_pkg::neg_sat(vel_q[1]);
					end
					state_q <= ST_DONE;
				end
				ST_RESTART: begin
					for (int i = 0; i < 3; i++) begin
						pos_q[i] <= start_q[i];
						vel_q[i] <= '0;
						acc_q[i] <= '0;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					// hold until the result register is free
					if (out_free) begin
						for (int i = 0; i < 3; i++) begin
							res_pos_q[i] <= pos_q[i];
							res_vel_q[i] <= vel_q[i];
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- tb/sv/tb_pebs_if.sv -----
`timescale 1ns / 1ps
// testbench side of the channels: the block's own interfaces are reused as is
// depends on pebs_pkg from the design
package tb_pebs_types;
	import pebs_pkg::*;

	typedef struct packed {
		logic [MODE_W-1:0]        mode;
		logic signed [WORD_W-1:0] fx;
		logic signed [WORD_W-1:0] fy;
		logic signed [WORD_W-1:0] fz;
		logic [DAMP_W-1:0]        damp;
	} cmd_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] px;
		logic signed [WORD_W-1:0] py;
		logic signed [WORD_W-1:0] pz;
		logic signed [WORD_W-1:0] vx;
		logic signed [WORD_W-1:0] vy;
		logic signed [WORD_W-1:0] vz;
	} state_t;
endpackage

// ----- tb/sv/tb_particle_euler_step_with_bounce.sv -----
`timescale 1ns / 1ps
// testbench for particle_euler_step_with_bounce: directed and random commands with
// random stalls, a particle model predicts every result; depends on pebs_pkg, the interfaces
module tb_particle_euler_step_with_bounce;
	import pebs_pkg::*;
	import tb_pebs_types::*;

	class particle_board;
		logic [AREA_W-1:0] aw, ah;
		logic [MASS_W-1:0] mass;
		logic signed [31:0] start [3];
		logic signed [31:0] p [3], v [3], a [3];
		state_t pending [$];
		int errors;

		function void clear();
			aw = AREA_W_RST; ah = AREA_H_RST; mass = MASS_RST;
			for (int k = 0; k < 3; k++) begin
				start[k] = 0; p[k] = 0; v[k] = 0; a[k] = 0;
			end
			errors = 0;
		endfunction

		function void write_reg(logic [CIDX_W-1:0] idx, logic [31:0] d);
			case (idx)
				REG_AREA_W: aw = d[AREA_W-1:0];
				REG_AREA_H: ah = d[AREA_W-1:0];
				REG_MASS: mass = d[MASS_W-1:0];
				REG_START_X: start[0] = d;
				REG_START_Y: start[1] = d;
				REG_START_Z: start[2] = d;
				default: ;
			endcase
		endfunction

		function logic signed [31:0] clamp(longint x);
			if (x > 64'sd2147483647) return 32'sh7fffffff;
			if (x < -64'sd2147483648) return 32'sh80000000;
			return x[31:0];
		endfunction

		function longint unsigned root(longint unsigned n);
			longint unsigned r, b;
			r = 0; b = 64'd1 << 62;
			while (b > n) b >>= 2;
			while (b != 0) begin
				if (n >= r + b) begin
					n -= r + b; r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		// 128-bit signed quotient truncated toward zero, then clamped
		function logic signed [31:0] divq(logic signed [127:0] num, logic signed [127:0] den);
			logic signed [127:0] q;
			q = num / den;
			if (q > 128'sd2147483647) return 32'sh7fffffff;
			if (q < -128'sd2147483648) return 32'sh80000000;
			return q[31:0];
		endfunction

		function void bounce(int k, logic [AREA_W-1:0] sz);
			logic signed [31:0] edge_pos;
			edge_pos = {1'b0, sz, 16'h0};
			if (p[k] < 0) begin
				p[k] = 0; v[k] = clamp(-longint'(v[k]));
			end
			if (p[k] > edge_pos) begin
				p[k] = edge_pos; v[k] = clamp(-longint'(v[k]));
			end
		endfunction

		function void note_cmd(cmd_t c);
			logic signed [31:0] f [3];
			longint unsigned sum, mag;
			longint m;
			state_t s;
			f[0] = c.fx; f[1] = c.fy; f[2] = c.fz;
			case (c.mode)
				MODE_FORCE: begin
					m = (mass == 0) ? 1 : mass;
					for (int k = 0; k < 3; k++)
						a[k] = clamp(longint'(a[k]) + divq(longint'(f[k]) * 256, m));
				end
				MODE_DAMP: begin
					sum = 0;
					for (int k = 0; k < 3; k++) sum += longint'(v[k]) * longint'(v[k]);
					if (sum != 0) begin
						mag = root(sum);
						for (int k = 0; k < 3; k++)
							a[k] = clamp(longint'(a[k]) - divq(longint'(v[k]) *
								longint'({1'b0, c.damp}), {64'd0, mag}));
					end
				end
				MODE_INTEG: begin
					for (int k = 0; k < 3; k++) begin
						v[k] = clamp(longint'(v[k]) + a[k]);
						p[k] = clamp(longint'(p[k]) + v[k]);
						a[k] = 0;
					end
				end
				MODE_BOUNCE: begin
					bounce(0, aw); bounce(1, ah);
				end
				MODE_RESTART: begin
					for (int k = 0; k < 3; k++) begin
						p[k] = start[k]; v[k] = 0; a[k] = 0;
					end
				end
				default: ;
			endcase
			s = '{p[0], p[1], p[2], v[0], v[1], v[2]};
			pending.push_back(s);
		endfunction

		function void check_result(state_t got);
			state_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result beat %p", got);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10) $display("mismatch: expected %p actual %p", want, got);
			end
		endfunction
	endclass

	logic clk, arst_n;
	pebs_cmd_if cmd ();
	pebs_res_if res ();
	pebs_cfg_if cfg ();
	particle_board board;
	bit done_stim, rx_quiet;

	particle_euler_step_with_bounce DUT (
		.clk(clk), .arst_n(arst_n), .cmd(cmd.sink), .result(res.source), .cfg(cfg.sink)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("status: fail");
		$finish;
	end

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom_range(0, 4) - 2;
			3: return $signed($urandom_range(0, 200000)) - 100000;
			default: return $urandom;
		endcase
	endfunction

	// valid stays high into the next beat when there is no gap
	task automatic send_cmd(cmd_t c, bit idle_ok);
		int gap;
		gap = idle_ok ? ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11)) : 0;
		if (gap != 0) begin
			cmd.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		cmd.valid <= 1; cmd.mode <= c.mode; cmd.force_x <= c.fx;
		cmd.force_y <= c.fy; cmd.force_z <= c.fz; cmd.damping <= c.damp;
		do @(posedge clk); while (!cmd.ready);
		board.note_cmd(c);
	endtask

	task automatic write_cfg(logic [CIDX_W-1:0] idx, logic [31:0] d);
		cfg.valid <= 1; cfg.index <= idx; cfg.data <= d;
		do @(posedge clk); while (!cfg.ready);
		board.write_reg(idx, d);
	endtask

	task automatic drain();
		cmd.valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic set_all(logic [31:0] w, logic [31:0] h, logic [31:0] m);
		write_cfg(REG_AREA_W, w); write_cfg(REG_AREA_H, h); write_cfg(REG_MASS, m);
		write_cfg(REG_START_X, rand_word()); write_cfg(REG_START_Y, rand_word());
		write_cfg(REG_START_Z, rand_word());
		write_cfg(3'd6, $urandom); write_cfg(3'd7, $urandom);
		cfg.valid <= 0;
	endtask

	function automatic cmd_t mk(logic [MODE_W-1:0] md);
		cmd_t c;
		c.mode = md; c.fx = rand_word(); c.fy = rand_word(); c.fz = rand_word();
		c.damp = ($urandom_range(0, 3) == 0) ? 31'h7fffffff : DAMP_W'($urandom_range(0, 300000));
		if ($urandom_range(0, 4) == 0) c.damp = DAMP_W'($urandom);
		return c;
	endfunction

	// result side: random stalls, with stall-free stretches
	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready)
			board.check_result('{res.pos_x, res.pos_y, res.pos_z, res.vel_x, res.vel_y, res.vel_z});
	end

	initial begin
		int hold;
		res.ready = 0;
		@(posedge arst_n);
		forever begin
			hold = rx_quiet ? 0 : $urandom_range(0, 11);
			res.ready <= (hold == 0);
			@(posedge clk);
			if (hold != 0) begin
				repeat (hold - 1) @(posedge clk);
				res.ready <= 1;
				@(posedge clk);
			end
			while (!(res.valid && res.ready)) @(posedge clk);
		end
	end

	initial begin
		cmd_t c;
		board = new();
		board.clear();
		arst_n = 0;
		cmd.valid = 0; cmd.mode = 0; cmd.force_x = 0; cmd.force_y = 0;
		cmd.force_z = 0; cmd.damping = 0;
		cfg.valid = 0; cfg.index = 0; cfg.data = 0;
		rx_quiet = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: damping on zero velocity, unused codes, extremes, bounce both walls
		c = mk(MODE_DAMP); send_cmd(c, 0);
		for (int md = 5; md < 8; md++) begin
			c = mk(MODE_W'(md)); send_cmd(c, 0);
		end
		c = '{MODE_FORCE, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 31'h7fffffff};
		send_cmd(c, 0);
		c.mode = MODE_INTEG; send_cmd(c, 0);
		c.mode = MODE_FORCE; send_cmd(c, 0);
		c.mode = MODE_INTEG; send_cmd(c, 0);
		c.mode = MODE_BOUNCE; send_cmd(c, 0);
		c.mode = MODE_DAMP; send_cmd(c, 0);
		c.mode = MODE_INTEG; send_cmd(c, 0);
		c.mode = MODE_BOUNCE; send_cmd(c, 0);
		c = '{MODE_FORCE, 32'h80000000, 32'h80000000, 32'h0, 31'h0}; send_cmd(c, 0);
		c.mode = MODE_INTEG; send_cmd(c, 0);
		c.mode = MODE_BOUNCE; send_cmd(c, 0);
		c.mode = MODE_DAMP; send_cmd(c, 0);
		c.mode = MODE_RESTART; send_cmd(c, 0);
		drain();
		// zero mass and zero area
		set_all(0, 0, 0);
		c = mk(MODE_FORCE); send_cmd(c, 0);
		c.mode = MODE_INTEG; send_cmd(c, 0);
		c.mode = MODE_BOUNCE; send_cmd(c, 0);
		c.mode = MODE_RESTART; send_cmd(c, 0);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_all(32767, 32767, 65535);
				1: set_all(1, 1, 1);
				default: set_all($urandom, $urandom, $urandom);
			endcase
			rx_quiet = (ph == 2);
			for (int n = 0; n < 250; n++) begin
				// mostly physics sequences: force, damp, integrate, bounce
				case ($urandom_range(0, 9))
					0, 1, 2: c = mk(MODE_FORCE);
					3, 4: c = mk(MODE_DAMP);
					5, 6: c = mk(MODE_INTEG);
					7: c = mk(MODE_BOUNCE);
					8: c = mk($urandom_range(0, 1) ? MODE_RESTART : MODE_INTEG);
					default: c = mk(MODE_W'($urandom_range(5, 7)));
				endcase
				send_cmd(c, ph != 3);
				if (n == 100) begin
					cmd.valid <= 0;
					while (board.pending.size() != 0) @(posedge clk);
				end
			end
			drain();
		end
		rx_quiet = 0;
		drain();
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule
